/* src/vfg_pkg.sv */
// ---------------------------------------------------------------------------
// vfg_pkg
// Shared widths, register codes, sideband types and the arctangent table
// of the vector field guidance pipeline.
// ---------------------------------------------------------------------------
package vfg_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int CORDIC_N   = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int CFG_IDX_W  = 4;
  localparam int LEN_W      = 34;
  localparam int DIST_W     = 35;
  localparam int Y0_W       = 51;
  localparam int CW         = 54;
  localparam int ZW         = 33;

  localparam logic [15:0] GAIN_RESET = 16'd6554;
  localparam logic [30:0] ONE30      = 31'h4000_0000;
  localparam logic [63:0] ONE60      = 64'h1000_0000_0000_0000;
  localparam logic [65:0] HALF30     = 66'h2000_0000;

  localparam logic signed [1:0] SIG_POS  = 2'sb01;
  localparam logic signed [1:0] SIG_NEG  = 2'sb11;
  localparam logic signed [1:0] SIG_ZERO = 2'sb00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE, REG_REF_X, REG_REF_Y, REG_DIR_X, REG_DIR_Y,
    REG_ORBIT_RADIUS, REG_SPEED, REG_GAIN
  } cfg_reg_t;

  // round(atan(2^-i) * 2/pi * 2^30)
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  // Travels with the squared length through the first square root.
  typedef struct packed {
    logic               ok;
    logic               neg_x;
    logic               neg_y;
    logic signed [32:0] op_x;
    logic signed [32:0] op_y;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic               down;
    logic [4:0]         up;
  } sb_pre_t;

  localparam int SB_W = $bits(sb_pre_t);

  typedef struct packed {
    logic               ok;
    logic               neg_x;
    logic               neg_y;
    logic signed [32:0] op_x;
    logic signed [32:0] op_y;
    logic [LEN_W-1:0]   len;
  } sb_div_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] e_x;
    logic signed [31:0] e_y;
    logic signed [1:0]  sig;
  } sb_cor_t;

  // Travels with 1 - k^2 through the second square root.
  typedef struct packed {
    logic               ok;
    logic signed [31:0] e_x;
    logic signed [31:0] e_y;
    logic signed [1:0]  sig;
    logic [30:0]        k;
  } sb_post_t;

endpackage

/* src/vector_field_guidance_unit.sv */
// ---------------------------------------------------------------------------
// vector_field_guidance_unit
// Vector field path following: turns a position into a commanded planar
// velocity that steers onto a configured line or circle.
// ---------------------------------------------------------------------------
//  channel   handshake               payload
//  input     start, busy             in_pos_x, in_pos_y
//  result    out_strobe              out_vel_x, out_vel_y, out_valid_res
//  config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// One item enters per cycle; busy is never raised. Each item passes through
// the two 32-stage square roots, the 31-stage divider and the CORDIC.
// Reset is synchronous and clears the valid bits and the configuration registers.
// The receiver must take every result in its strobe cycle; the block itself
// does not enforce this, and nothing stalls.
module vector_field_guidance_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [31:0]                in_pos_x,
  input  logic signed [31:0]                in_pos_y,
  output logic                              out_strobe,
  output logic signed [16:0]                out_vel_x,
  output logic signed [16:0]                out_vel_y,
  output logic                              out_valid_res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vfg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import vfg_pkg::*;

  // Configuration registers
  logic               mode_r;
  logic signed [31:0] ref_x_r, ref_y_r, dir_x_r, dir_y_r, orbit_radius_r;
  logic [15:0]        speed_r, gain_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= 1'b0;
      ref_x_r        <= '0;
      ref_y_r        <= '0;
      dir_x_r        <= '0;
      dir_y_r        <= '0;
      orbit_radius_r <= '0;
      speed_r        <= '0;
      gain_r         <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:         mode_r         <= cfg_data[0];
        REG_REF_X:        ref_x_r        <= cfg_data;
        REG_REF_Y:        ref_y_r        <= cfg_data;
        REG_DIR_X:        dir_x_r        <= cfg_data;
        REG_DIR_Y:        dir_y_r        <= cfg_data;
        REG_ORBIT_RADIUS: orbit_radius_r <= cfg_data;
        REG_SPEED:        speed_r        <= cfg_data[15:0];
        REG_GAIN:         gain_r         <= cfg_data[15:0];
        default:          ;
      endcase
    end
  end

  // Valid bits of the top-level stages
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic v8_r, v9_r, v10_r, v11_r, v12_r, v13_r, v14_r;
  logic v15_r, v16_r, v17_r, v18_r;
  logic sq1_valid, div_valid, cor_valid, sq2_valid;

  // Stage 1: vector to normalize and offset from the line origin.
  logic signed [32:0] pos_x_e, pos_y_e, ref_x_e, ref_y_e, dir_x_e, dir_y_e;
  logic signed [32:0] vx_nxt, vy_nxt;
  logic signed [32:0] vx1_r, vy1_r, op_x1_r, op_y1_r;

  always_comb begin
    pos_x_e = {in_pos_x[31], in_pos_x};
    pos_y_e = {in_pos_y[31], in_pos_y};
    ref_x_e = {ref_x_r[31], ref_x_r};
    ref_y_e = {ref_y_r[31], ref_y_r};
    dir_x_e = {dir_x_r[31], dir_x_r};
    dir_y_e = {dir_y_r[31], dir_y_r};
    vx_nxt  = mode_r ? (ref_x_e - pos_x_e) : dir_x_e;
    vy_nxt  = mode_r ? (ref_y_e - pos_y_e) : dir_y_e;
  end

  always_ff @(posedge clk) begin
    vx1_r   <= vx_nxt;
    vy1_r   <= vy_nxt;
    op_x1_r <= pos_x_e - ref_x_e;
    op_y1_r <= pos_y_e - ref_y_e;
  end

  // Stage 2: magnitudes; halve when the larger one reaches 2^31.
  logic [32:0] mag_x2, mag_y2, max2;
  logic        down2;
  sb_pre_t     pre2_nxt, pre2_r;

  always_comb begin
    mag_x2 = vx1_r[32] ? 33'(-vx1_r) : 33'(vx1_r);
    mag_y2 = vy1_r[32] ? 33'(-vy1_r) : 33'(vy1_r);
    max2   = (mag_x2 > mag_y2) ? mag_x2 : mag_y2;
    down2  = |max2[32:31];
    pre2_nxt.ok    = (max2 != '0);
    pre2_nxt.neg_x = vx1_r[32];
    pre2_nxt.neg_y = vy1_r[32];
    pre2_nxt.op_x  = op_x1_r;
    pre2_nxt.op_y  = op_y1_r;
    pre2_nxt.ax    = down2 ? mag_x2[32:1] : mag_x2[31:0];
    pre2_nxt.ay    = down2 ? mag_y2[32:1] : mag_y2[31:0];
    pre2_nxt.down  = down2;
    pre2_nxt.up    = '0;
  end

  always_ff @(posedge clk) begin
    pre2_r <= pre2_nxt;
  end

  // Stage 3: left shift that brings the larger magnitude to [2^30, 2^31].
  logic [31:0] max3;
  logic [4:0]  up3;
  sb_pre_t     pre3_nxt, pre3_r;

  always_comb begin
    max3 = (pre2_r.ax > pre2_r.ay) ? pre2_r.ax : pre2_r.ay;
    up3  = '0;
    for (int i = 0; i < 30; i++) begin
      if (max3[i]) begin
        up3 = 5'(30 - i);
      end
    end
    if (|max3[31:30]) begin
      up3 = '0;
    end
    pre3_nxt    = pre2_r;
    pre3_nxt.up = up3;
  end

  always_ff @(posedge clk) begin
    pre3_r <= pre3_nxt;
  end

  // Stage 4: apply the shift.
  sb_pre_t pre4_nxt, pre4_r;

  always_comb begin
    pre4_nxt    = pre3_r;
    pre4_nxt.ax = pre3_r.ax << pre3_r.up;
    pre4_nxt.ay = pre3_r.ay << pre3_r.up;
  end

  always_ff @(posedge clk) begin
    pre4_r <= pre4_nxt;
  end

  // Stages 5 and 6: squared length.
  logic [63:0] sq_x5_r, sq_y5_r, sum6_r;
  sb_pre_t     pre5_r, pre6_r;

  always_ff @(posedge clk) begin
    sq_x5_r <= 64'(pre4_r.ax) * 64'(pre4_r.ax);
    sq_y5_r <= 64'(pre4_r.ay) * 64'(pre4_r.ay);
    pre5_r  <= pre4_r;
    sum6_r  <= sq_x5_r + sq_y5_r;
    pre6_r  <= pre5_r;
  end

  logic [31:0]     root1;
  logic [SB_W-1:0] sb1_out;
  sb_pre_t         pre7;

  vfg_isqrt u_len_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v6_r),
    .in_val    (sum6_r),
    .in_sb     (SB_W'(pre6_r)),
    .out_valid (sq1_valid),
    .out_root  (root1),
    .out_sb    (sb1_out)
  );

  // Length in the original scale feeds the circle distance.
  sb_div_t div_in_sb;

  always_comb begin
    pre7            = sb_pre_t'(sb1_out);
    div_in_sb.ok    = pre7.ok;
    div_in_sb.neg_x = pre7.neg_x;
    div_in_sb.neg_y = pre7.neg_y;
    div_in_sb.op_x  = pre7.op_x;
    div_in_sb.op_y  = pre7.op_y;
    div_in_sb.len   = pre7.down ? {1'b0, root1, 1'b0} : LEN_W'(root1 >> pre7.up);
  end

  logic [30:0] q_x, q_y;
  sb_div_t     div_sb;

  vfg_div u_unit_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq1_valid),
    .in_num_x  (pre7.ax),
    .in_num_y  (pre7.ay),
    .in_den    (root1),
    .in_sb     (div_in_sb),
    .out_valid (div_valid),
    .out_q_x   (q_x),
    .out_q_y   (q_y),
    .out_sb    (div_sb)
  );

  // Stage 8: tangent direction, and distance and side for the circle.
  logic signed [31:0]     n_x, n_y, e_x_nxt, e_y_nxt;
  logic                   rho_pos;
  logic signed [1:0]      rho, sig8_nxt;
  logic [31:0]            ar;
  logic signed [LEN_W:0]  rdiff;
  logic [DIST_W-1:0]      dist8_nxt;
  logic signed [31:0]     e_x8_r, e_y8_r;
  logic signed [32:0]     op_x8_r, op_y8_r;
  logic signed [1:0]      sig8_r;
  logic [DIST_W-1:0]      dist8_r;
  logic                   ok8_r;

  always_comb begin
    n_x     = div_sb.neg_x ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
    n_y     = div_sb.neg_y ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
    rho_pos = !(orbit_radius_r > 32'sd0);
    rho     = rho_pos ? SIG_POS : SIG_NEG;
    ar      = orbit_radius_r[31] ? 32'(-orbit_radius_r) : 32'(orbit_radius_r);
    rdiff   = $signed({1'b0, div_sb.len}) - $signed({3'b0, ar});
    dist8_nxt = rdiff[LEN_W] ? DIST_W'(-rdiff) : DIST_W'(rdiff);
    if (div_sb.len > LEN_W'(ar)) begin
      sig8_nxt = rho;
    end else if (div_sb.len < LEN_W'(ar)) begin
      sig8_nxt = -rho;
    end else begin
      sig8_nxt = SIG_ZERO;
    end
    if (mode_r) begin
      e_x_nxt = rho_pos ? -n_y : n_y;
      e_y_nxt = rho_pos ? n_x : -n_x;
    end else begin
      e_x_nxt = n_x;
      e_y_nxt = n_y;
    end
  end

  always_ff @(posedge clk) begin
    e_x8_r  <= e_x_nxt;
    e_y8_r  <= e_y_nxt;
    op_x8_r <= div_sb.op_x;
    op_y8_r <= div_sb.op_y;
    sig8_r  <= sig8_nxt;
    dist8_r <= dist8_nxt;
    ok8_r   <= div_sb.ok;
  end

  // Stage 9: cross product terms for the signed line distance.
  logic signed [64:0]     pa9_r, pb9_r;
  logic signed [31:0]     e_x9_r, e_y9_r;
  logic signed [1:0]      sig9_r;
  logic [DIST_W-1:0]      dist9_r;
  logic                   ok9_r;

  always_ff @(posedge clk) begin
    pa9_r   <= e_x8_r * op_y8_r;
    pb9_r   <= e_y8_r * op_x8_r;
    e_x9_r  <= e_x8_r;
    e_y9_r  <= e_y8_r;
    sig9_r  <= sig8_r;
    dist9_r <= dist8_r;
    ok9_r   <= ok8_r;
  end

  // Stage 10: line distance and side, then the mode selects.
  logic signed [65:0] s10;
  logic [65:0]        s_mag;
  logic signed [1:0]  sig10_nxt;
  logic [DIST_W-1:0]  dist10_nxt, dist10_r;
  sb_cor_t            cor10_r, cor11_r;
  logic [Y0_W-1:0]    y0_11_r;

  always_comb begin
    s10   = 66'(pa9_r) - 66'(pb9_r);
    s_mag = s10[65] ? 66'(-s10) : 66'(s10);
    if (mode_r) begin
      sig10_nxt  = sig9_r;
      dist10_nxt = dist9_r;
    end else begin
      dist10_nxt = s_mag[64:30];
      if (s10[65]) begin
        sig10_nxt = SIG_NEG;
      end else if (s10 != '0) begin
        sig10_nxt = SIG_POS;
      end else begin
        sig10_nxt = SIG_ZERO;
      end
    end
  end

  always_ff @(posedge clk) begin
    dist10_r    <= dist10_nxt;
    cor10_r.ok  <= ok9_r;
    cor10_r.e_x <= e_x9_r;
    cor10_r.e_y <= e_y9_r;
    cor10_r.sig <= sig10_nxt;
    // Stage 11: argument of the arctangent.
    y0_11_r     <= Y0_W'(dist10_r) * Y0_W'(gain_r);
    cor11_r     <= cor10_r;
  end

  logic [30:0] k_out;
  sb_cor_t     cor_sb;

  vfg_cordic u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v11_r),
    .in_y      (y0_11_r),
    .in_sb     (cor11_r),
    .out_valid (cor_valid),
    .out_k     (k_out),
    .out_sb    (cor_sb)
  );

  // Stages 12 to 14: 1 - k^2 in Q60.
  logic [30:0] k12_r, k13_r;
  sb_cor_t     cor12_r, cor13_r;
  logic [61:0] kk13_r;
  logic [63:0] arg14_r;
  sb_post_t    post14_r;

  always_ff @(posedge clk) begin
    k12_r          <= k_out;
    cor12_r        <= cor_sb;
    kk13_r         <= 62'(k12_r) * 62'(k12_r);
    k13_r          <= k12_r;
    cor13_r        <= cor12_r;
    arg14_r        <= ONE60 - {2'b0, kk13_r};
    post14_r.ok    <= cor13_r.ok;
    post14_r.e_x   <= cor13_r.e_x;
    post14_r.e_y   <= cor13_r.e_y;
    post14_r.sig   <= cor13_r.sig;
    post14_r.k     <= k13_r;
  end

  logic [31:0]     root2;
  logic [SB_W-1:0] sb2_out;
  sb_post_t        post15;

  vfg_isqrt u_blend_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v14_r),
    .in_val    (arg14_r),
    .in_sb     (SB_W'(post14_r)),
    .out_valid (sq2_valid),
    .out_root  (root2),
    .out_sb    (sb2_out)
  );

  assign post15 = sb_post_t'(sb2_out[$bits(sb_post_t)-1:0]);

  // Stage 15: blend products.
  logic signed [31:0] c_s, k_s;
  logic signed [63:0] ce_x15_r, ce_y15_r, ke_x15_r, ke_y15_r;
  logic signed [1:0]  sig15_r;
  logic               ok15_r;

  assign c_s = $signed({1'b0, root2[30:0]});
  assign k_s = $signed({1'b0, post15.k});

  always_ff @(posedge clk) begin
    ce_x15_r <= c_s * post15.e_x;
    ce_y15_r <= c_s * post15.e_y;
    ke_x15_r <= k_s * post15.e_x;
    ke_y15_r <= k_s * post15.e_y;
    sig15_r  <= post15.sig;
    ok15_r   <= post15.ok;
  end

  // Stage 16: velocity direction in Q60.
  logic signed [64:0] wx_nxt, wy_nxt, wx16_r, wy16_r;
  logic               ok16_r;

  always_comb begin
    wx_nxt = 65'(ce_x15_r);
    wy_nxt = 65'(ce_y15_r);
    if (sig15_r == SIG_POS) begin
      wx_nxt = wx_nxt + 65'(ke_y15_r);
      wy_nxt = wy_nxt - 65'(ke_x15_r);
    end else if (sig15_r == SIG_NEG) begin
      wx_nxt = wx_nxt - 65'(ke_y15_r);
      wy_nxt = wy_nxt + 65'(ke_x15_r);
    end
  end

  always_ff @(posedge clk) begin
    wx16_r <= wx_nxt;
    wy16_r <= wy_nxt;
    ok16_r <= ok15_r;
  end

  // Stage 17: round the magnitude to Q30.
  logic [65:0] rx17, ry17;
  logic [35:0] wq_x17_r, wq_y17_r;
  logic        neg_x17_r, neg_y17_r, ok17_r;

  always_comb begin
    rx17 = (wx16_r[64] ? 66'(-wx16_r) : 66'(wx16_r)) + HALF30;
    ry17 = (wy16_r[64] ? 66'(-wy16_r) : 66'(wy16_r)) + HALF30;
  end

  always_ff @(posedge clk) begin
    wq_x17_r  <= rx17[65:30];
    wq_y17_r  <= ry17[65:30];
    neg_x17_r <= wx16_r[64];
    neg_y17_r <= wy16_r[64];
    ok17_r    <= ok16_r;
  end

  // Stage 18: scale by speed, round to Q8.8, saturate, apply the sign.
  logic [52:0]        px18, py18;
  logic [15:0]        sat_x, sat_y;
  logic signed [16:0] vel_x_nxt, vel_y_nxt, vel_x_r, vel_y_r;
  logic               valid_res_r;

  always_comb begin
    px18  = 53'(wq_x17_r) * 53'(speed_r) + 53'(HALF30);
    py18  = 53'(wq_y17_r) * 53'(speed_r) + 53'(HALF30);
    sat_x = (|px18[52:46]) ? 16'hFFFF : px18[45:30];
    sat_y = (|py18[52:46]) ? 16'hFFFF : py18[45:30];
    vel_x_nxt = neg_x17_r ? -$signed({1'b0, sat_x}) : $signed({1'b0, sat_x});
    vel_y_nxt = neg_y17_r ? -$signed({1'b0, sat_y}) : $signed({1'b0, sat_y});
    if (!ok17_r) begin
      vel_x_nxt = '0;
      vel_y_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    vel_x_r     <= vel_x_nxt;
    vel_y_r     <= vel_y_nxt;
    valid_res_r <= ok17_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
      v13_r <= 1'b0;
      v14_r <= 1'b0;
      v15_r <= 1'b0;
      v16_r <= 1'b0;
      v17_r <= 1'b0;
      v18_r <= 1'b0;
    end else begin
      v1_r  <= start && !busy;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v8_r  <= div_valid;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= cor_valid;
      v13_r <= v12_r;
      v14_r <= v13_r;
      v15_r <= sq2_valid;
      v16_r <= v15_r;
      v17_r <= v16_r;
      v18_r <= v17_r;
    end
  end

  assign out_strobe    = v18_r;
  assign out_vel_x     = vel_x_r;
  assign out_vel_y     = vel_y_r;
  assign out_valid_res = valid_res_r;

endmodule

/* src/vfg_isqrt.sv */
// ---------------------------------------------------------------------------
// vfg_isqrt
// Pipelined floored integer square root of a 64-bit value, one result bit
// per stage, with a sideband word carried alongside.
// ---------------------------------------------------------------------------
module vfg_isqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [63:0]              in_val,
  input  logic [vfg_pkg::SB_W-1:0] in_sb,
  output logic                     out_valid,
  output logic [31:0]              out_root,
  output logic [vfg_pkg::SB_W-1:0] out_sb
);
  import vfg_pkg::*;

  logic            vld_r  [SQRT_STEPS];
  logic [63:0]     rem_r  [SQRT_STEPS];
  logic [63:0]     root_r [SQRT_STEPS];
  logic [SB_W-1:0] sb_r   [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic            vld_in;
    logic [63:0]     rem_in;
    logic [63:0]     root_in;
    logic [SB_W-1:0] sb_in;
    logic [63:0]     trial;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_val;
      assign root_in = '0;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign sb_in   = sb_r[i-1];
    end

    assign trial = root_in + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      if (rem_in >= trial) begin
        rem_r[i]  <= rem_in - trial;
        root_r[i] <= (root_in >> 1) + BIT;
      end else begin
        rem_r[i]  <= rem_in;
        root_r[i] <= root_in >> 1;
      end
      sb_r[i] <= sb_in;
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign out_root  = root_r[SQRT_STEPS-1][31:0];
  assign out_sb    = sb_r[SQRT_STEPS-1];

endmodule

/* src/vfg_div.sv */
// ---------------------------------------------------------------------------
// vfg_div
// Pipelined restoring divider that turns the scaled components into unit
// vector components: q = (a * 2^30) / r, one quotient bit per stage.
// ---------------------------------------------------------------------------
module vfg_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [31:0]      in_num_x,
  input  logic [31:0]      in_num_y,
  input  logic [31:0]      in_den,
  input  vfg_pkg::sb_div_t in_sb,
  output logic             out_valid,
  output logic [30:0]      out_q_x,
  output logic [30:0]      out_q_y,
  output vfg_pkg::sb_div_t out_sb
);
  import vfg_pkg::*;

  logic        vld_r   [DIV_STEPS];
  logic [61:0] rem_x_r [DIV_STEPS];
  logic [61:0] rem_y_r [DIV_STEPS];
  logic [30:0] q_x_r   [DIV_STEPS];
  logic [30:0] q_y_r   [DIV_STEPS];
  logic [31:0] den_r   [DIV_STEPS];
  sb_div_t     sb_r    [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    localparam int P = DIV_STEPS - 1 - i;
    logic        vld_in;
    logic [61:0] rem_x_in, rem_y_in, dsh;
    logic [30:0] q_x_in, q_y_in;
    logic [31:0] den_in;
    sb_div_t     sb_in;
    logic [61:0] rem_x_nxt, rem_y_nxt;
    logic [30:0] q_x_nxt, q_y_nxt;

    if (i == 0) begin : g_first
      assign vld_in   = in_valid;
      assign rem_x_in = {in_num_x, 30'b0};
      assign rem_y_in = {in_num_y, 30'b0};
      assign q_x_in   = '0;
      assign q_y_in   = '0;
      assign den_in   = in_den;
      assign sb_in    = in_sb;
    end else begin : g_next
      assign vld_in   = vld_r[i-1];
      assign rem_x_in = rem_x_r[i-1];
      assign rem_y_in = rem_y_r[i-1];
      assign q_x_in   = q_x_r[i-1];
      assign q_y_in   = q_y_r[i-1];
      assign den_in   = den_r[i-1];
      assign sb_in    = sb_r[i-1];
    end

    assign dsh = {30'b0, den_in} << P;

    always_comb begin
      rem_x_nxt = rem_x_in;
      rem_y_nxt = rem_y_in;
      q_x_nxt   = q_x_in;
      q_y_nxt   = q_y_in;
      if (rem_x_in >= dsh) begin
        rem_x_nxt  = rem_x_in - dsh;
        q_x_nxt[P] = 1'b1;
      end
      if (rem_y_in >= dsh) begin
        rem_y_nxt  = rem_y_in - dsh;
        q_y_nxt[P] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      rem_x_r[i] <= rem_x_nxt;
      rem_y_r[i] <= rem_y_nxt;
      q_x_r[i]   <= q_x_nxt;
      q_y_r[i]   <= q_y_nxt;
      den_r[i]   <= den_in;
      sb_r[i]    <= sb_in;
    end
  end

  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_q_x   = (q_x_r[DIV_STEPS-1] > ONE30) ? ONE30 : q_x_r[DIV_STEPS-1];
  assign out_q_y   = (q_y_r[DIV_STEPS-1] > ONE30) ? ONE30 : q_y_r[DIV_STEPS-1];
  assign out_sb    = sb_r[DIV_STEPS-1];

endmodule

/* src/vfg_cordic.sv */
// ---------------------------------------------------------------------------
// vfg_cordic
// Pipelined vectoring CORDIC that maps d * gain to the blend factor
// k = (2/pi) * atan(d * gain) in Q1.30, one rotation per stage.
// ---------------------------------------------------------------------------
module vfg_cordic (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [vfg_pkg::Y0_W-1:0] in_y,
  input  vfg_pkg::sb_cor_t         in_sb,
  output logic                     out_valid,
  output logic [30:0]              out_k,
  output vfg_pkg::sb_cor_t         out_sb
);
  import vfg_pkg::*;

  logic                 vld_r  [CORDIC_N];
  logic                 zero_r [CORDIC_N];
  logic signed [CW-1:0] x_r    [CORDIC_N];
  logic signed [CW-1:0] y_r    [CORDIC_N];
  logic signed [ZW-1:0] z_r    [CORDIC_N];
  sb_cor_t              sb_r   [CORDIC_N];

  logic signed [ZW-1:0] z_last;

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = $signed({{(ZW-30){1'b0}}, ATAN_TAB[i]});
    logic                 vld_in, zero_in;
    logic signed [CW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0] z_in;
    sb_cor_t              sb_in;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign zero_in = (in_y == '0);
      assign x_in    = $signed(CW'(64'd1 << 32));
      assign y_in    = $signed({{(CW-Y0_W){1'b0}}, in_y});
      assign z_in    = '0;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign zero_in = zero_r[i-1];
      assign x_in    = x_r[i-1];
      assign y_in    = y_r[i-1];
      assign z_in    = z_r[i-1];
      assign sb_in   = sb_r[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      if (!y_in[CW-1]) begin
        x_r[i] <= x_in + dx;
        y_r[i] <= y_in - dy;
        z_r[i] <= z_in + ANG;
      end else begin
        x_r[i] <= x_in - dx;
        y_r[i] <= y_in + dy;
        z_r[i] <= z_in - ANG;
      end
      zero_r[i] <= zero_in;
      sb_r[i]   <= sb_in;
    end
  end

  assign z_last = z_r[CORDIC_N-1];

  always_comb begin
    if (zero_r[CORDIC_N-1] || z_last[ZW-1]) begin
      out_k = '0;
    end else if (z_last > $signed({2'b0, ONE30})) begin
      out_k = ONE30;
    end else begin
      out_k = z_last[30:0];
    end
  end

  assign out_valid = vld_r[CORDIC_N-1];
  assign out_sb    = sb_r[CORDIC_N-1];

endmodule
